// ----- hdl/vni_pkg.sv -----
// ---------------------------------------------------------------------------
// vni_pkg
// Shared widths and the status type for the vector norm / integer square root.
// ---------------------------------------------------------------------------
`default_nettype none

package vni_pkg;

  localparam int unsigned VAL_W   = 32;
  localparam int unsigned ROOT_W  = VAL_W / 2;
  localparam int unsigned REM_W   = ROOT_W + 2;
  localparam int unsigned STEPS   = VAL_W / 2;
  localparam int unsigned CNT_W   = $clog2(STEPS);
  localparam int unsigned COMP_W  = 16;

  localparam logic OP_ROOT = 1'b0;
  localparam logic OP_NORM = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } core_status_t;

endpackage

`default_nettype wire

// ----- hdl/vni_sqrt_core.sv -----
// ---------------------------------------------------------------------------
// vni_sqrt_core
// Digit-serial floor square root: two radicand bits enter per cycle from a
// shift register, one root bit leaves per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module vni_sqrt_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            load,
  input  wire logic [vni_pkg::VAL_W-1:0]       value,
  output vni_pkg::core_status_t                status,
  output logic      [vni_pkg::ROOT_W-1:0]      root
);

  logic [vni_pkg::VAL_W-1:0]  val_r,  val_nxt;
  logic [vni_pkg::REM_W-1:0]  rem_r,  rem_nxt;
  logic [vni_pkg::ROOT_W-1:0] root_r, root_nxt;
  logic [vni_pkg::CNT_W-1:0]  cnt_r,  cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;

  logic [vni_pkg::REM_W+1:0]  rem_sh;
  logic [vni_pkg::REM_W+1:0]  trial;
  logic [vni_pkg::REM_W+1:0]  diff;
  logic                       ge;

  always_comb begin
    rem_sh = {rem_r, val_r[vni_pkg::VAL_W-1 -: 2]};
    trial  = {2'b00, root_r, 2'b01};
    diff   = rem_sh - trial;
    ge     = (rem_sh >= trial);
  end

  always_comb begin
    val_nxt  = val_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (load) begin
      val_nxt  = value;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      val_nxt  = {val_r[vni_pkg::VAL_W-3:0], 2'b00};
      rem_nxt  = ge ? diff[vni_pkg::REM_W-1:0] : rem_sh[vni_pkg::REM_W-1:0];
      root_nxt = {root_r[vni_pkg::ROOT_W-2:0], ge};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == vni_pkg::CNT_W'(vni_pkg::STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign root        = root_r;

endmodule

`default_nettype wire

// ----- hdl/vector_norm_isqrt.sv -----
// ---------------------------------------------------------------------------
// vector_norm_isqrt
// Floor square root of a radicand (opcode 0, negative gives 0) or floor
// Euclidean norm of (x, y) (opcode 1), one root bit per cycle.
// ---------------------------------------------------------------------------
//  channel | ports                                         | direction
//  input   | in_valid in_stall in_opcode in_radicand       | in (stall out)
//          | in_vec_x in_vec_y                             |
//  result  | out_valid out_stall out_root                  | out (stall in)
//
//  One beat in, one beat out; a new beat is taken only in idle. Opcode 1
//  first squares x, then y, on the shared 16x16 squarer; both opcodes then
//  run sixteen root steps in the serial core, wait for done and post.
//  Reset clears the sequencer and output valid. A stalled result holds the
//  block in its post state; the held beat keeps its value.
// ---------------------------------------------------------------------------
`default_nettype none

module vector_norm_isqrt (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic                                   in_opcode,
  input  wire logic signed [vni_pkg::VAL_W-1:0]       in_radicand,
  input  wire logic signed [vni_pkg::COMP_W-1:0]      in_vec_x,
  input  wire logic signed [vni_pkg::COMP_W-1:0]      in_vec_y,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic             [vni_pkg::ROOT_W-1:0]      out_root
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SQX  = 5'b00010,
    ST_SQY  = 5'b00100,
    ST_RUN  = 5'b01000,
    ST_POST = 5'b10000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [vni_pkg::COMP_W-1:0]     mag_x_r, mag_x_nxt;
  logic [vni_pkg::COMP_W-1:0]     mag_y_r, mag_y_nxt;
  logic [vni_pkg::VAL_W-1:0]      sum_r,   sum_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [vni_pkg::ROOT_W-1:0]     out_root_r,  out_root_nxt;

  logic [vni_pkg::COMP_W-1:0]     mul_op;
  logic [2*vni_pkg::COMP_W-1:0]   prod;
  logic                           accept;
  logic                           core_load;
  logic [vni_pkg::VAL_W-1:0]      core_value;
  vni_pkg::core_status_t          core_status;
  logic [vni_pkg::ROOT_W-1:0]     core_root;

  function automatic logic [vni_pkg::COMP_W-1:0] magnitude(
    input logic signed [vni_pkg::COMP_W-1:0] v
  );
    logic [vni_pkg::COMP_W-1:0] neg;
    neg = vni_pkg::COMP_W'(-v);
    return v[vni_pkg::COMP_W-1] ? neg : v;
  endfunction

  assign accept = in_valid && !in_stall;
  assign mul_op = (state_r == ST_SQX) ? mag_x_r : mag_y_r;
  assign prod   = mul_op * mul_op;

  always_comb begin
    state_nxt     = state_r;
    mag_x_nxt     = mag_x_r;
    mag_y_nxt     = mag_y_r;
    sum_nxt       = sum_r;
    out_root_nxt  = out_root_r;
    out_valid_nxt = out_valid_r && out_stall;
    core_load     = 1'b0;
    core_value    = sum_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_opcode == vni_pkg::OP_NORM) begin
            mag_x_nxt = magnitude(in_vec_x);
            mag_y_nxt = magnitude(in_vec_y);
            state_nxt = ST_SQX;
          end else begin
            core_load  = 1'b1;
            core_value = in_radicand[vni_pkg::VAL_W-1] ? '0 : in_radicand;
            state_nxt  = ST_RUN;
          end
        end
      end
      ST_SQX: begin
        sum_nxt   = prod;
        state_nxt = ST_SQY;
      end
      ST_SQY: begin
        core_load  = 1'b1;
        core_value = sum_r + prod;
        state_nxt  = ST_RUN;
      end
      ST_RUN: begin
        if (core_status.done) begin
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        if (!out_valid_r || !out_stall) begin
          out_root_nxt  = core_root;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_x_r    <= mag_x_nxt;
    mag_y_r    <= mag_y_nxt;
    sum_r      <= sum_nxt;
    out_root_r <= out_root_nxt;
  end

  vni_sqrt_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (core_load),
    .value  (core_value),
    .status (core_status),
    .root   (core_root)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_root  = out_root_r;

endmodule

`default_nettype wire

// ----- verif/tb_vector_norm_isqrt.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_vector_norm_isqrt
// Self-checking bench for the square root / vector norm unit. A directed
// table covers zero, negative and full-scale radicands and the corner
// vectors. Random beats follow, some near perfect squares, small values or
// corner vectors. Both channels get random gaps. Each result is compared in
// order against the row's typed root or a bench-side digit-by-digit model.
// ---------------------------------------------------------------------------

module tb_vector_norm_isqrt;

  localparam int unsigned VAL_W  = vni_pkg::VAL_W;
  localparam int unsigned ROOT_W = vni_pkg::ROOT_W;
  localparam int unsigned COMP_W = vni_pkg::COMP_W;
  localparam logic OP_ROOT = vni_pkg::OP_ROOT;
  localparam logic OP_NORM = vni_pkg::OP_NORM;
  localparam int unsigned DIGIT_LIMIT = 3;
  localparam int DIR_N  = 22;
  localparam int RAND_N = 850;

  typedef struct packed {
    logic              op;
    logic [VAL_W-1:0]  rad;
    logic [COMP_W-1:0] vx;
    logic [COMP_W-1:0] vy;
    logic              typed;
    logic [ROOT_W-1:0] root;
  } stim_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_opcode = OP_ROOT;
  logic signed [VAL_W-1:0]  in_radicand = '0;
  logic signed [COMP_W-1:0] in_vec_x = '0;
  logic signed [COMP_W-1:0] in_vec_y = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic        [ROOT_W-1:0] out_root;

  logic [ROOT_W-1:0] root_expect_q [$];
  int                mismatch_cnt = 0;
  bit                quiet = 1'b0;

  stim_row_t directed_rows [DIR_N] = '{
    '{OP_ROOT, 32'd0,          16'h0000, 16'h0000, 1'b1, 16'd0},
    '{OP_ROOT, 32'd1,          16'h1234, 16'h8000, 1'b1, 16'd1},
    '{OP_ROOT, 32'd3,          16'h0000, 16'h0000, 1'b1, 16'd1},
    '{OP_ROOT, 32'd4,          16'hFFFF, 16'hFFFF, 1'b1, 16'd2},
    '{OP_ROOT, 32'd15,         16'h0000, 16'h0000, 1'b1, 16'd3},
    '{OP_ROOT, 32'd16,         16'h0000, 16'h0000, 1'b1, 16'd4},
    '{OP_ROOT, 32'h7FFF_FFFF,  16'h7FFF, 16'h7FFF, 1'b1, 16'd46340},
    '{OP_ROOT, 32'hFFFF_FFFF,  16'h0000, 16'h0000, 1'b1, 16'd0},
    '{OP_ROOT, 32'h8000_0000,  16'h7FFF, 16'h8000, 1'b1, 16'd0},
    '{OP_ROOT, 32'd2147395600, 16'h0000, 16'h0000, 1'b1, 16'd46340},
    '{OP_ROOT, 32'd2147395599, 16'h0000, 16'h0000, 1'b1, 16'd46339},
    '{OP_ROOT, 32'd65536,      16'h8000, 16'h7FFF, 1'b1, 16'd256},
    '{OP_ROOT, 32'd99999999,   16'h5555, 16'hAAAA, 1'b0, 16'd0},
    '{OP_NORM, 32'hFFFF_FFFF,  16'h0000, 16'h0000, 1'b1, 16'd0},
    '{OP_NORM, 32'd12345,      16'd3,    16'd4,    1'b1, 16'd5},
    '{OP_NORM, 32'd0,          16'h8000, 16'h8000, 1'b1, 16'd46340},
    '{OP_NORM, 32'h7FFF_FFFF,  16'h7FFF, 16'h7FFF, 1'b0, 16'd0},
    '{OP_NORM, 32'h8000_0000,  16'h8000, 16'h0000, 1'b1, 16'd32768},
    '{OP_NORM, 32'd77,         16'h0000, 16'h7FFF, 1'b1, 16'd32767},
    '{OP_NORM, 32'd0,          16'hFFFF, 16'hFFFF, 1'b1, 16'd1},
    '{OP_NORM, 32'h7FFF_FFFF,  16'd1,    16'd0,    1'b1, 16'd1},
    '{OP_NORM, 32'hAAAA_5555,  16'h8000, 16'h7FFF, 1'b0, 16'd0}
  };

  vector_norm_isqrt uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_opcode  (in_opcode),
    .in_radicand(in_radicand),
    .in_vec_x   (in_vec_x),
    .in_vec_y   (in_vec_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_root   (out_root)
  );

  always #1 clk = ~clk;

  function automatic logic [ROOT_W-1:0] predict_root(input logic op,
                                                     input logic [VAL_W-1:0] rad,
                                                     input logic [COMP_W-1:0] vx,
                                                     input logic [COMP_W-1:0] vy);
    longint      sx;
    longint      sy;
    logic [63:0] v;
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] d;
    int          n;
    int          i;
    sx = $signed(vx);
    sy = $signed(vy);
    if (op == OP_NORM) begin
      v = {32'd0, 32'(sx * sx + sy * sy)};
    end else begin
      v = rad[VAL_W-1] ? 64'd0 : {32'd0, rad};
    end
    n = 0;
    for (m = v; m > DIGIT_LIMIT; m = m >> 2) n++;
    q = '0;
    for (i = n; i >= 0; i--) begin
      d = (q | (64'd1 << i)) << i;
      if (v >= d) begin
        v = v - d;
        q = q | (64'd2 << i);
      end
    end
    return q[ROOT_W:1];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_beat(input logic op, input logic [VAL_W-1:0] rad,
                           input logic [COMP_W-1:0] vx, input logic [COMP_W-1:0] vy,
                           input logic typed, input logic [ROOT_W-1:0] want);
    int gap;
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_radicand <= rad;
    in_vec_x    <= vx;
    in_vec_y    <= vy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    root_expect_q.push_back(typed ? want : predict_root(op, rad, vx, vy));
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (root_expect_q.size() != 0) @(posedge clk);
  endtask

  // result stall generator
  initial begin : stall_gen
    int n;
    forever begin
      n = pick_gap();
      if (n == 0) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (root_expect_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual root %0d",
                 $time, out_root);
        mismatch_cnt++;
      end else if (out_root !== root_expect_q[0]) begin
        $display("%0t: root mismatch, expected %0d, actual %0d",
                 $time, root_expect_q[0], out_root);
        mismatch_cnt++;
        void'(root_expect_q.pop_front());
      end else begin
        void'(root_expect_q.pop_front());
      end
    end
  end

  initial begin : stimulus
    int          k;
    int          sel;
    int unsigned r;
    logic        op;
    logic [31:0] rad;
    logic [15:0] vx;
    logic [15:0] vy;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < DIR_N; k++) begin
      send_beat(directed_rows[k].op, directed_rows[k].rad, directed_rows[k].vx,
                directed_rows[k].vy, directed_rows[k].typed, directed_rows[k].root);
    end
    drain_results();

    for (k = 0; k < RAND_N; k++) begin
      quiet = (k >= 400 && k < 480);
      if (k == 250) drain_results();
      op  = 1'($urandom_range(0, 1));
      rad = $urandom;
      vx  = 16'($urandom);
      vy  = 16'($urandom);
      sel = $urandom_range(0, 9);
      if (op == OP_ROOT) begin
        case (sel)
          0, 1: rad = $urandom_range(0, 300);
          2, 3: begin
            r   = $urandom_range(0, 46340);
            rad = r * r - $urandom_range(0, 1);
          end
          4, 5: rad[31] = 1'b0;
          default: ;
        endcase
      end else begin
        case (sel)
          0, 1: begin
            vx = 16'($urandom_range(0, 40)) - 16'd20;
            vy = 16'($urandom_range(0, 40)) - 16'd20;
          end
          2: vy = '0;
          3: vx = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
          4: begin
            vx = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            vy = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
          end
          default: ;
        endcase
      end
      send_beat(op, rad, vx, vy, 1'b0, '0);
    end
    quiet = 1'b0;

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0 && root_expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #1500000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
